>>> design/itoa_pkg.sv
// shared constants and types for the signed integer to decimal text converter
package itoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;

  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
  localparam logic [CNT_W-1:0]   LAST_SHIFT = 5'd31;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SHIFT  = 4'b0010,
    ST_LOCATE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

endpackage

>>> design/signed_int_to_decimal_ascii_core.sv
// Signed 32-bit integer to decimal ASCII text.
// Input channel: value with in_valid / in_stall; a beat is taken when in_valid
// is high and in_stall low. in_stall is high while a conversion or its text is
// still being produced; it drops again once the last character has been loaded
// into the output register, even if that character still waits there.
// Output channel: char_code and last with out_valid / out_stall; one character
// per beat, most significant first, '-' leading for negative values, last set
// on the final digit. Leading zeros are not sent, so zero gives one '0'.
// Timing: after the input beat the magnitude is shifted through a chain of ten
// decimal digit cells, one bit per cycle in 32 steps, then a locate step finds
// the leading digit, then one character is loaded per cycle while the output
// is not stalled (n = 1 to 11 characters per item). When the receiver does not
// stall, the 32-step bit-serial pass through the cell chain takes up most of the
// time of an item.
// A stall on the output simply holds the current character and pauses the text.
// Reset (rst, synchronous) returns to idle and drops out_valid; no state is kept
// between items.
module signed_int_to_decimal_ascii_core
  import itoa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VALUE_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAR_W-1:0]        char_code,
  output logic                     last
);

  state_t               state;
  logic [VALUE_W-1:0]   mag;
  logic [CNT_W-1:0]     cnt;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     top_idx;
  logic                 sign_pend;
  logic                 accept;
  logic                 can_load;
  logic                 shift_en;
  logic [NUM_DIGITS:0]  carry;
  digit_t               digit [NUM_DIGITS];
  digit_t               digit_sel;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign can_load = !out_valid || !out_stall;
  assign shift_en = (state == ST_SHIFT);
  assign carry[0] = mag[VALUE_W-1];

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    itoa_bcd_cell u_cell (
      .clk       (clk),
      .clr       (accept),
      .shift_en  (shift_en),
      .shift_in  (carry[g]),
      .shift_out (carry[g+1]),
      .digit     (digit[g])
    );
  end

  // highest non-zero digit, digit 0 when the value is zero
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (digit[i] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign digit_sel = digit[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      idx       <= '0;
      sign_pend <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // magnitude as unsigned, so the most negative value is exact
            mag       <= value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(value))
                                          : $unsigned(value);
            sign_pend <= value[VALUE_W-1];
            cnt       <= '0;
            state     <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          mag <= {mag[VALUE_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == LAST_SHIFT) begin
            state <= ST_LOCATE;
          end
        end
        ST_LOCATE: begin
          idx   <= top_idx;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_load) begin
            if (sign_pend) begin
              char_code <= CHAR_MINUS;
              last      <= 1'b0;
              sign_pend <= 1'b0;
            end else begin
              char_code <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit_sel};
              last      <= (idx == '0);
              if (idx == '0) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx - 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // ten digits always hold a 32-bit magnitude, nothing spills off the top cell
  a_no_spill: assert property (@(posedge clk) disable iff (rst)
    shift_en |-> !carry[NUM_DIGITS])
    else $error("digit chain overflow");

  a_bcd_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && !sign_pend |-> (digit_sel <= DIGIT_MAX))
    else $error("digit cell left a non-decimal value");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (char_code == CHAR_MINUS) |-> !last)
    else $error("sign sent as the final character");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SHIFT) && (cnt == '0))
    else $error("conversion did not start after input beat");
`endif

endmodule

>>> design/itoa_bcd_cell.sv
// one decimal digit cell of the shift-and-add-3 chain
module itoa_bcd_cell
  import itoa_pkg::*;
(
  input  logic   clk,
  input  logic   clr,
  input  logic   shift_en,
  input  logic   shift_in,
  output logic   shift_out,
  output digit_t digit
);

  digit_t adj;

  // a digit of five or more overflows when doubled, so bias it by three first
  always_comb begin
    adj = (digit >= 4'd5) ? digit + 4'd3 : digit;
  end

  assign shift_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    if (clr) begin
      digit <= '0;
    end else if (shift_en) begin
      digit <= {adj[DIGIT_W-2:0], shift_in};
    end
  end

endmodule

>>> tb/tb.sv
// testbench for the signed integer to decimal ascii text converter
`timescale 1ns / 1ps

module tb;
  import itoa_pkg::*;

  localparam int unsigned DECIMAL_BASE = 10;
  localparam int          IDLE_PCT     = 25;
  localparam int          DRAIN_CYCLES = 80;
  localparam longint      CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [CHAR_W-1:0]         char_code;
  logic                      last;

  text_char_t expected_text[$];
  int         mismatches   = 0;
  int         numbers_sent = 0;
  int         negatives    = 0;
  int         chars_seen   = 0;
  longint     cycles       = 0;
  bit         idle_in      = 1'b1;
  bit         idle_out     = 1'b1;

  signed_int_to_decimal_ascii_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last      (last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  // sign first, then digits most significant first, last flag on the final digit
  function automatic void predict_decimal_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    digit_t             digits[NUM_DIGITS];
    int                 nd;
    text_char_t         c;
    mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
    nd  = 0;
    do begin
      digits[nd] = digit_t'(mag % DECIMAL_BASE);
      mag        = mag / DECIMAL_BASE;
      nd++;
    end while (mag != 0 && nd < NUM_DIGITS);
    if (v[VALUE_W-1]) begin
      c.code    = CHAR_MINUS;
      c.is_last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code    = CHAR_ZERO + CHAR_W'(digits[i]);
      c.is_last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // valid is only lowered on an idle cycle, so back-to-back beats keep it high
  task automatic send_value(input logic [VALUE_W-1:0] v);
    while (idle_in && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      value    <= $urandom;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_decimal_text(v);
    numbers_sent++;
    if (v[VALUE_W-1]) negatives++;
  endtask

  // magnitude of a random digit count, often at a decade boundary, random sign; sometimes a fully random word
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned ndig, lo, hi, mag;
    ndig = $urandom_range(1, NUM_DIGITS);
    lo   = 1;
    repeat (ndig - 1) lo = lo * DECIMAL_BASE;
    hi   = (ndig == NUM_DIGITS) ? 32'h8000_0000 : lo * DECIMAL_BASE - 1;
    if (ndig == 1) lo = 0;
    case ($urandom_range(0, 5))
      0:       mag = lo;
      1:       mag = hi;
      2:       return $urandom;
      default: mag = $urandom_range(hi, lo);
    endcase
    return $urandom_range(1) ? (~mag + 1) : mag;
  endfunction

  task automatic test_directed();
    logic [VALUE_W-1:0] vals[$];
    vals = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
             32'd999999999, -32'sd999999999, -32'sd1000000000, 32'h5555_5555,
             32'hAAAA_AAAA, 32'd1234567890, -32'sd1234567890, 32'd7, -32'sd9};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_mixed(input int n);
    repeat (n) send_value(pick_value());
  endtask

  // long stretch with neither side idling
  task automatic test_back_to_back(input int n);
    idle_in  = 1'b0;
    idle_out = 1'b0;
    repeat (n) send_value(pick_value());
    idle_in  = 1'b1;
    idle_out = 1'b1;
  endtask

  task automatic test_full_range(input int n);
    repeat (n) send_value($urandom);
  endtask

  always @(posedge clk) begin
    text_char_t exp_c;
    cycles <= cycles + 1;
    out_stall <= idle_out && ($urandom_range(99) < IDLE_PCT);
    if (!rst && out_valid && !out_stall) begin
      chars_seen++;
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last %0b", char_code, last));
      end else begin
        exp_c = expected_text.pop_front();
        if (char_code !== exp_c.code)
          report_mismatch($sformatf("char_code %0d, expected %0d", char_code, exp_c.code));
        if (last !== exp_c.is_last)
          report_mismatch($sformatf("last %0b, expected %0b", last, exp_c.is_last));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout with %0d characters outstanding", expected_text.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mixed(60);
    test_back_to_back(40);
    test_full_range(50);
    in_valid <= 1'b0;
    while (expected_text.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    foreach (expected_text[i])
      report_mismatch($sformatf("missing character %0d", expected_text[i].code));
    $display("converted %0d numbers (%0d negative), checked %0d characters",
             numbers_sent, negatives, chars_seen);
    $display("%0d mismatches in %0d cycles", mismatches, cycles);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/itoa_pkg.sv
design/itoa_bcd_cell.sv
design/signed_int_to_decimal_ascii_core.sv
tb/tb.sv
